### sv/two_button_long_press_handler_assert.svh
// Assertion macros used by the checker file of this block.
// Each macro expands to one labeled concurrent assertion that reports by $error.
`ifndef TWO_BUTTON_LONG_PRESS_HANDLER_ASSERT_SVH
`define TWO_BUTTON_LONG_PRESS_HANDLER_ASSERT_SVH

// Checked only outside reset.
`define TBLP_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// Checked in every cycle, reset included.
`define TBLP_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) prop) else $error(msg);

`endif

### sv/tblp_pkg.sv
// ----------------------------------------------------------------------------
// tblp_pkg
// Types, widths and reset values of the two-button long-press handler.
// ----------------------------------------------------------------------------
package tblp_pkg;

    localparam int SWATCH_W   = 8;
    localparam int MODE_W     = 3;
    localparam int HOLD_W     = 16;
    localparam int DEBOUNCE_W = 8;
    localparam int TIME_W     = 32;
    localparam int CFG_IDX_W  = 4;
    localparam int CFG_DATA_W = 16;

    localparam int MODE_COUNT_DEFAULT = 5;

    localparam logic [SWATCH_W-1:0]   RESET_SWATCH_COUNT = 8'd8;
    localparam logic [HOLD_W-1:0]     RESET_HOLD_TIME    = 16'd2000;
    localparam logic                  RESET_ANIM_PRESENT = 1'b1;
    localparam logic [DEBOUNCE_W-1:0] RESET_DEBOUNCE     = 8'd20;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_SWATCH_COUNT   = 4'd0,
        CFG_HOLD_TIME      = 4'd1,
        CFG_ANIM_PRESENT   = 4'd2,
        CFG_DEBOUNCE       = 4'd3
    } t_cfg_index;

    typedef struct packed {
        logic [SWATCH_W-1:0]   swatch_count;
        logic [HOLD_W-1:0]     hold_time_ms;
        logic                  anim_button_present;
        logic [DEBOUNCE_W-1:0] debounce_reload;
    } t_cfg;

    typedef struct packed {
        logic              color_level;
        logic              anim_level;
        logic              preview_busy;
        logic [TIME_W-1:0] now_ms;
    } t_in;

    typedef struct packed {
        logic [SWATCH_W-1:0] swatch_index;
        logic [MODE_W-1:0]   anim_mode;
        logic                brightness_mode;
        logic                swatch_preview_start;
        logic                anim_preview_start;
    } t_out;

    typedef struct packed {
        logic                  color_last;
        logic                  anim_last;
        logic [DEBOUNCE_W-1:0] debounce_left;
        logic [TIME_W-1:0]     press_start_time;
        logic                  long_held;
        logic [SWATCH_W-1:0]   swatch;
        logic [MODE_W-1:0]     mode;
        logic                  bright;
    } t_state;

endpackage

### sv/tblp_step.sv
// ----------------------------------------------------------------------------
// tblp_step
// Next-state and result logic for one frame tick: debounce countdown,
// press timing, brightness mode, swatch and mode advance.
// ----------------------------------------------------------------------------
module tblp_step
    import tblp_pkg::*;
#(
    parameter int MODE_COUNT = MODE_COUNT_DEFAULT
) (
    input  t_cfg   i_cfg,
    input  t_state i_state,
    input  t_in    i_tick,
    output t_state o_state,
    output t_out   o_res
);

    localparam logic [MODE_W:0] ModeCount = (MODE_W+1)'(MODE_COUNT);

    logic [TIME_W-1:0]   elapsed;
    logic                hold_hit;
    logic [SWATCH_W:0]   swatch_inc;
    logic [SWATCH_W-1:0] swatch_next;
    logic [MODE_W:0]     mode_inc;
    logic [MODE_W-1:0]   mode_next;
    logic                sw_pulse;
    logic                an_pulse;

    assign elapsed  = i_tick.now_ms - i_state.press_start_time;
    assign hold_hit = elapsed >= {{(TIME_W-HOLD_W){1'b0}}, i_cfg.hold_time_ms};

    assign swatch_inc  = {1'b0, i_state.swatch} + (SWATCH_W+1)'(1);
    assign swatch_next = (swatch_inc >= {1'b0, i_cfg.swatch_count}) ?
                         '0 : swatch_inc[SWATCH_W-1:0];

    assign mode_inc  = {1'b0, i_state.mode} + (MODE_W+1)'(1);
    assign mode_next = (mode_inc >= ModeCount) ? '0 : mode_inc[MODE_W-1:0];

    always_comb begin
        o_state  = i_state;
        sw_pulse = 1'b0;
        an_pulse = 1'b0;
        if (!i_tick.preview_busy) begin
            if (i_state.debounce_left != '0) begin
                o_state.debounce_left = i_state.debounce_left - DEBOUNCE_W'(1);
            end else begin
                if (i_tick.color_level != i_state.color_last) begin
                    if (!i_tick.color_level) begin
                        o_state.press_start_time = i_tick.now_ms;
                    end else if (!i_state.long_held) begin
                        o_state.swatch = swatch_next;
                        sw_pulse       = 1'b1;
                    end else begin
                        o_state.bright = 1'b0;
                    end
                    o_state.long_held  = 1'b0;
                    o_state.color_last = i_tick.color_level;
                end else if (!i_tick.color_level && !i_state.long_held && hold_hit) begin
                    o_state.long_held = 1'b1;
                    o_state.bright    = 1'b1;
                end

                // With no animation button wired, its level is not even sampled.
                if (i_cfg.anim_button_present &&
                    (i_tick.anim_level != i_state.anim_last)) begin
                    if (!i_tick.anim_level) begin
                        o_state.mode = mode_next;
                        an_pulse     = 1'b1;
                    end
                    o_state.anim_last = i_tick.anim_level;
                end

                o_state.debounce_left = i_cfg.debounce_reload;
            end
        end
    end

    always_comb begin
        o_res.swatch_index         = o_state.swatch;
        o_res.anim_mode            = o_state.mode;
        o_res.brightness_mode      = o_state.bright;
        o_res.swatch_preview_start = sw_pulse;
        o_res.anim_preview_start   = an_pulse;
    end

endmodule

### sv/two_button_long_press_handler.sv
// ----------------------------------------------------------------------------
// two_button_long_press_handler
// Debounced two-button handler with short-press swatch stepping and
// long-press brightness mode.
// ----------------------------------------------------------------------------
// Every input beat is one frame tick and yields exactly one result beat. The
// block takes one tick per clock cycle until back-pressure fills both registers,
// and a tick passes through two register stages in order: the input register,
// then the result register. Between them, the button state is updated in a
// single pass that holds a 32-bit elapsed-time subtract and compare. The input
// register keeps accepting while a result waits downstream, so one stalled
// result costs no throughput until both registers are full. Configuration
// writes are taken in any cycle and should be issued only while no tick is in
// flight.
module two_button_long_press_handler
    import tblp_pkg::*;
#(
    parameter int MODE_COUNT = MODE_COUNT_DEFAULT
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    input  logic                  i_in_valid,
    output logic                  o_in_ready,
    input  t_in                   i_in,
    output logic                  o_out_valid,
    input  logic                  i_out_ready,
    output t_out                  o_out
);

    t_cfg   r_cfg;
    t_state r_state;
    t_state n_state;
    logic   r_in_valid;
    t_in    r_in;
    logic   r_out_valid;
    t_out   r_out;
    t_out   n_out;
    logic   advance;

    assign o_cfg_ready = 1'b1;
    assign advance     = r_in_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready  = !r_in_valid || advance;
    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

    tblp_step #(
        .MODE_COUNT(MODE_COUNT)
    ) u_step (
        .i_cfg   (r_cfg),
        .i_state (r_state),
        .i_tick  (r_in),
        .o_state (n_state),
        .o_res   (n_out)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.swatch_count        <= RESET_SWATCH_COUNT;
            r_cfg.hold_time_ms        <= RESET_HOLD_TIME;
            r_cfg.anim_button_present <= RESET_ANIM_PRESENT;
            r_cfg.debounce_reload     <= RESET_DEBOUNCE;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_SWATCH_COUNT: begin
                    r_cfg.swatch_count <= i_cfg_data[SWATCH_W-1:0];
                end
                CFG_HOLD_TIME: begin
                    r_cfg.hold_time_ms <= i_cfg_data[HOLD_W-1:0];
                end
                CFG_ANIM_PRESENT: begin
                    r_cfg.anim_button_present <= i_cfg_data[0];
                end
                CFG_DEBOUNCE: begin
                    r_cfg.debounce_reload <= i_cfg_data[DEBOUNCE_W-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state.color_last       <= 1'b1;
            r_state.anim_last        <= 1'b1;
            r_state.debounce_left    <= '0;
            r_state.press_start_time <= '0;
            r_state.long_held        <= 1'b0;
            r_state.swatch           <= '0;
            r_state.mode             <= '0;
            r_state.bright           <= 1'b0;
        end else if (advance) begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_in <= i_in;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_out <= n_out;
        end
    end

endmodule

### sv/tblp_checker.sv
// ----------------------------------------------------------------------------
// tblp_checker
// Port-level assertions for the two-button long-press handler, bound to
// the top level.
// ----------------------------------------------------------------------------
`include "two_button_long_press_handler_assert.svh"

module tblp_checker
    import tblp_pkg::*;
#(
    parameter int MODE_COUNT = MODE_COUNT_DEFAULT
) (
    input logic i_clk,
    input logic i_rst_n,
    input logic o_out_valid,
    input logic i_out_ready,
    input t_out o_out
);

    localparam logic [MODE_W:0] ModeCount = (MODE_W+1)'(MODE_COUNT);

    // A result beat that waits downstream keeps its payload.
    `TBLP_ASSERT(a_out_hold, o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_out), "result changed while stalled")

    // Reset empties the result register.
    `TBLP_ASSERT_ALWAYS(a_reset_empty, !i_rst_n |=> !o_out_valid, "result valid right after reset")

    // Brightness mode is only on while the color button is held after a long
    // press, so a short-press release can never leave it set.
    `TBLP_ASSERT(a_short_press_bright, o_out_valid && o_out.swatch_preview_start |-> !o_out.brightness_mode, "short press seen in brightness mode")

    // An animation advance always lands on a mode inside the wrap range.
    `TBLP_ASSERT(a_mode_range, o_out_valid && o_out.anim_preview_start |-> {1'b0, o_out.anim_mode} < ModeCount, "animation mode out of range")

endmodule

bind two_button_long_press_handler tblp_checker #(
    .MODE_COUNT(MODE_COUNT)
) u_tblp_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .o_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .o_out       (o_out)
);
